>>> hdl/lcx_pkg.sv
// ----------------------------------------------------------------------------
// lcx_pkg
// shared types and constants for the line-c execute core
// ----------------------------------------------------------------------------
package lcx_pkg;

    // operation classes produced by the decoder
    typedef enum logic [2:0] {
        OP_AND,
        OP_MULU,
        OP_MULS,
        OP_ABCD,
        OP_EXG,
        OP_ILL
    } t_op;

    // operand size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;
    localparam logic [1:0] SZ_MUL  = 2'd3;

    // exchange mode codes, opcode bits 7..3
    localparam logic [4:0] EXG_DD = 5'h08;
    localparam logic [4:0] EXG_AA = 5'h09;
    localparam logic [4:0] EXG_DA = 5'h11;

    // bcd correction constants
    localparam logic [4:0] BCD_DIGIT_LIM = 5'd10;
    localparam logic [9:0] BCD_LO_ADJ    = 10'h006;
    localparam logic [9:0] BCD_HI_LIM    = 10'h0A0;
    localparam logic [9:0] BCD_HI_ADJ    = 10'h060;

    // one decoded item as it travels from front to back
    typedef struct packed {
        t_op         op;
        logic [1:0]  size;
        logic [31:0] src;
        logic [31:0] dst;
        logic        x;
        logic        z;
        logic        n;
        logic        v;
        logic        c;
    } t_item;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> hdl/lcx_front.sv
// ----------------------------------------------------------------------------
// lcx_front
// accepts instruction items and classifies the opcode
// ----------------------------------------------------------------------------
module lcx_front
    import lcx_pkg::*;
(
    input  logic        i_start,
    input  logic [15:0] i_opcode,
    input  logic [31:0] i_src_operand,
    input  logic [31:0] i_dst_operand,
    input  logic        i_x_in,
    input  logic        i_z_in,
    input  logic        i_n_in,
    input  logic        i_v_in,
    input  logic        i_c_in,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_item       o_item
);

    logic [7:0] lo;
    logic [1:0] sz;
    logic       dir;
    logic [4:0] mode;
    t_op        op;

    assign lo   = i_opcode[7:0];
    assign sz   = lo[7:6];
    assign dir  = i_opcode[8];
    assign mode = lo[7:3];

    always_comb begin
        if (sz == SZ_MUL) begin
            op = dir ? OP_MULS : OP_MULU;
        end else if (dir && (lo[7:4] == 4'd0)) begin
            op = OP_ABCD;
        end else if (dir && (lo[5:4] == 2'd0)) begin
            if ((mode == EXG_DD) || (mode == EXG_AA) || (mode == EXG_DA)) begin
                op = OP_EXG;
            end else begin
                op = OP_ILL;
            end
        end else begin
            op = OP_AND;
        end
    end

    assign o_push = i_start && !i_q_stat.full;

    always_comb begin
        o_item.op   = op;
        o_item.size = sz;
        o_item.src  = i_src_operand;
        o_item.dst  = i_dst_operand;
        o_item.x    = i_x_in;
        o_item.z    = i_z_in;
        o_item.n    = i_n_in;
        o_item.v    = i_v_in;
        o_item.c    = i_c_in;
    end

endmodule

>>> hdl/lcx_queue.sv
// ----------------------------------------------------------------------------
// lcx_queue
// small fifo of decoded items between front and back
// ----------------------------------------------------------------------------
module lcx_queue
    import lcx_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // fill level stays within the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    // no write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("push into full queue");

    // no read from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("pop from empty queue");

    // pointers meet whenever the count is zero
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

>>> hdl/lcx_back.sv
// ----------------------------------------------------------------------------
// lcx_back
// carries out one decoded item per cycle while the queue is not empty and registers the result
// ----------------------------------------------------------------------------
module lcx_back
    import lcx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_done,
    output logic [31:0] o_result,
    output logic [31:0] o_second_result,
    output logic [1:0]  o_op_size,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_v,
    output logic        o_flag_c,
    output logic        o_flag_x,
    output logic        o_illegal,
    output logic        o_is_exchange
);

    logic               r_done;
    logic [31:0]        r_result,  n_result;
    logic [31:0]        r_result2, n_result2;
    logic [1:0]         r_size,    n_size;
    logic               r_n, n_n, r_z, n_z, r_v, n_v, r_c, n_c, r_x, n_x;
    logic               r_ill,  n_ill;
    logic               r_xchg, n_xchg;

    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    logic [31:0]        and_full;
    logic [31:0]        and_res;
    logic               and_sign;
    logic [8:0]         bcd_t;
    logic [4:0]         bcd_lo;
    logic [9:0]         bcd_r1, bcd_r2;
    logic               bcd_c;
    logic [7:0]         bcd_r;
    logic [9:0]         bcd_a;

    assign o_pop = !i_q_stat.empty;

    // shared 17x17 signed multiplier covers both mulu and muls
    always_comb begin
        mul_a = {(i_item.op == OP_MULS) && i_item.src[15], i_item.src[15:0]};
        mul_b = {(i_item.op == OP_MULS) && i_item.dst[15], i_item.dst[15:0]};
        mul_p = mul_a * mul_b;
    end

    // and, masked to size
    always_comb begin
        and_full = i_item.src & i_item.dst;
        case (i_item.size)
            SZ_BYTE: begin
                and_res  = {24'd0, and_full[7:0]};
                and_sign = and_full[7];
            end
            SZ_WORD: begin
                and_res  = {16'd0, and_full[15:0]};
                and_sign = and_full[15];
            end
            default: begin
                and_res  = and_full;
                and_sign = and_full[31];
            end
        endcase
    end

    // packed bcd add with extend
    always_comb begin
        bcd_t  = {1'b0, i_item.dst[7:0]} + {1'b0, i_item.src[7:0]} + {8'd0, i_item.x};
        bcd_lo = {1'b0, i_item.dst[3:0]} + {1'b0, i_item.src[3:0]} + {4'd0, i_item.x};
        bcd_r1 = {1'b0, bcd_t};
        if (bcd_lo >= BCD_DIGIT_LIM) begin
            bcd_r1 = bcd_r1 + BCD_LO_ADJ;
        end
        bcd_r2 = bcd_r1;
        bcd_c  = 1'b0;
        if (bcd_r1 >= BCD_HI_LIM) begin
            bcd_r2 = bcd_r1 + BCD_HI_ADJ;
            bcd_c  = 1'b1;
        end
        bcd_r = bcd_r2[7:0];
        bcd_a = {2'b00, bcd_r} - {1'b0, bcd_t};
    end

    always_comb begin
        n_result  = '0;
        n_result2 = '0;
        n_size    = SZ_BYTE;
        n_n       = i_item.n;
        n_z       = i_item.z;
        n_v       = i_item.v;
        n_c       = i_item.c;
        n_x       = i_item.x;
        n_ill     = 1'b0;
        n_xchg    = 1'b0;
        unique case (i_item.op)
            OP_MULU, OP_MULS: begin
                n_result = mul_p[31:0];
                n_size   = SZ_LONG;
                n_n      = mul_p[31];
                n_z      = (mul_p[31:0] == 32'd0);
                n_v      = 1'b0;
                n_c      = 1'b0;
            end
            OP_ABCD: begin
                n_result = {24'd0, bcd_r};
                n_c      = bcd_c;
                n_x      = bcd_c;
                n_z      = (bcd_r != 8'd0) ? 1'b0 : i_item.z;
                n_n      = bcd_r[7];
                n_v      = (bcd_t[7] ^ bcd_r[7]) & (bcd_a[7] ^ bcd_r[7]);
            end
            OP_EXG: begin
                n_result  = i_item.dst;
                n_result2 = i_item.src;
                n_size    = SZ_LONG;
                n_xchg    = 1'b1;
            end
            OP_ILL: begin
                n_ill = 1'b1;
            end
            default: begin
                n_result = and_res;
                n_size   = i_item.size;
                n_n      = and_sign;
                n_z      = (and_res == 32'd0);
                n_v      = 1'b0;
                n_c      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result  <= n_result;
            r_result2 <= n_result2;
            r_size    <= n_size;
            r_n       <= n_n;
            r_z       <= n_z;
            r_v       <= n_v;
            r_c       <= n_c;
            r_x       <= n_x;
            r_ill     <= n_ill;
            r_xchg    <= n_xchg;
        end
    end

    assign o_done          = r_done;
    assign o_result        = r_result;
    assign o_second_result = r_result2;
    assign o_op_size       = r_size;
    assign o_flag_n        = r_n;
    assign o_flag_z        = r_z;
    assign o_flag_v        = r_v;
    assign o_flag_c        = r_c;
    assign o_flag_x        = r_x;
    assign o_illegal       = r_ill;
    assign o_is_exchange   = r_xchg;

endmodule

>>> hdl/line_c_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// line_c_instruction_execute_core
// execute unit for 68000 line-c words: and, mulu, muls, abcd, exg
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low, one item per
// cycle with no gaps. Its result is registered on the next edge and sits on
// the o_ ports for the cycle after that edge, marked by o_done for exactly one
// cycle; the receiver cannot stall, so the back end drains the queue every
// cycle and busy only rises if the queue fills. The back end has the single
// 17x17 signed multiplier shared by mulu and muls. Operands arrive already
// fetched; the unit returns the write-back values and the new flags only.
module line_c_instruction_execute_core
    import lcx_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_opcode,
    input  logic [31:0] i_src_operand,
    input  logic [31:0] i_dst_operand,
    input  logic        i_x_in,
    input  logic        i_z_in,
    input  logic        i_n_in,
    input  logic        i_v_in,
    input  logic        i_c_in,
    output logic        o_done,
    output logic [31:0] o_result,
    output logic [31:0] o_second_result,
    output logic [1:0]  o_op_size,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_v,
    output logic        o_flag_c,
    output logic        o_flag_x,
    output logic        o_illegal,
    output logic        o_is_exchange
);

    // front to queue
    logic    push;
    t_item   front_item;
    // queue to back
    t_item   q_item;
    t_q_stat q_stat;
    logic    pop;

    // front: take the item and classify the opcode
    lcx_front u_front (
        .i_start       (start),
        .i_opcode      (i_opcode),
        .i_src_operand (i_src_operand),
        .i_dst_operand (i_dst_operand),
        .i_x_in        (i_x_in),
        .i_z_in        (i_z_in),
        .i_n_in        (i_n_in),
        .i_v_in        (i_v_in),
        .i_c_in        (i_c_in),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_item        (front_item)
    );

    // decoupling queue
    lcx_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // back: execute and register the result
    lcx_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (q_stat),
        .i_item          (q_item),
        .o_pop           (pop),
        .o_done          (o_done),
        .o_result        (o_result),
        .o_second_result (o_second_result),
        .o_op_size       (o_op_size),
        .o_flag_n        (o_flag_n),
        .o_flag_z        (o_flag_z),
        .o_flag_v        (o_flag_v),
        .o_flag_c        (o_flag_c),
        .o_flag_x        (o_flag_x),
        .o_illegal       (o_illegal),
        .o_is_exchange   (o_is_exchange)
    );

    // busy only when the queue has no room
    assign busy = q_stat.full;

    // an exchange is long sized and never illegal
    a_exg_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_exchange) |-> (!o_illegal && (o_op_size == SZ_LONG)))
        else $error("exchange result malformed");

    // an illegal word writes nothing
    a_ill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_illegal) |-> ((o_result == 32'd0) && (o_second_result == 32'd0)))
        else $error("illegal word produced data");

    // an accepted item reaches the back end on the next cycle
    a_accept_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> pop)
        else $error("accepted item not drained");

endmodule
